// ===== rtl/core/tcw_pkg.sv =====
// shared constants, codes and helpers of the text console writer
package tcw_pkg;

   localparam int MAX_COLUMNS = 80;
   localparam int ROW_LIMIT   = 25;
   localparam int CELL_COUNT  = MAX_COLUMNS * ROW_LIMIT;
   localparam int ADDR_W      = $clog2(CELL_COUNT);

   // field widths fixed by the item layout
   localparam int CMD_W   = 3;
   localparam int CHAR_W  = 8;
   localparam int COL_W   = 7;
   localparam int ROW_W   = 5;
   localparam int POS_W   = 11;
   localparam int CELL_W  = 16;
   localparam int REQ_W   = 24;
   localparam int RSP_W   = 32;
   localparam int CSR_AW  = 4;
   localparam int CSR_DW  = 32;

   localparam logic [CMD_W-1:0] CMD_PRINT     = 3'd0;
   localparam logic [CMD_W-1:0] CMD_SET_CUR   = 3'd1;
   localparam logic [CMD_W-1:0] CMD_CLR_ROW   = 3'd2;
   localparam logic [CMD_W-1:0] CMD_CLR_SCR   = 3'd3;
   localparam logic [CMD_W-1:0] CMD_READ_CELL = 3'd4;

   localparam logic [1:0] REG_COLOUR  = 2'd0;
   localparam logic [1:0] REG_COLUMNS = 2'd1;
   localparam logic [1:0] REG_ROWS    = 2'd2;

   localparam logic [CHAR_W-1:0] BLANK_CHAR   = 8'h20;
   localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'h0A;
   localparam logic [CHAR_W-1:0] RESET_COLOUR = 8'h0F;
   localparam logic [COL_W-1:0]  RESET_COLS   = COL_W'(MAX_COLUMNS);
   localparam logic [ROW_W-1:0]  RESET_ROWS   = ROW_W'(ROW_LIMIT);

   function automatic logic [ADDR_W-1:0] cell_addr(input logic [COL_W-1:0] col,
                                                   input logic [ROW_W-1:0] row);
      cell_addr = ADDR_W'(col) + ADDR_W'(row) * ADDR_W'(MAX_COLUMNS);
   endfunction

endpackage

// ===== rtl/core/tcw_ram.sv =====
// generic simple dual-port ram with registered read
module tcw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/text_console_writer.sv =====
// text console writer: cell buffer, cursor and command sequencer
//
// channel  dir  handshake        payload
// req      in   tvalid/tready    tuser: command; tdata: char, column, row
// rsp      out  tvalid/tready    tdata: cursor position, cell char, cell colour
// csr      in   apb write/read   colour, screen columns, screen rows
//
// set cursor and unknown commands only answer, print writes one cell and read cell
// reads one; a newline or clear row wipes one row, clear screen wipes every row
// and a scroll moves the rows up and wipes the last; the single write port of the
// cell ram sets how long these take, one cell written per cycle.
// after reset a clearing pass over all 2000 cells blanks the ram; no item is taken
// meanwhile. a new item is taken while a result still waits at the output.
module text_console_writer
   import tcw_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [REQ_W-1:0]  req_tdata,   // char_code[7:0], column_pos[14:8], row_pos[19:15]
   input  logic [CMD_W-1:0]  req_tuser,   // command[2:0]
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [RSP_W-1:0]  rsp_tdata,   // cursor_position[10:0], cell_char[18:11],
                                          // cell_colour[26:19]
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready
);

   typedef enum logic [7:0] {
      S_CLEAR       = 8'b00000001,
      S_IDLE        = 8'b00000010,
      S_WIPE        = 8'b00000100,
      S_SCROLL      = 8'b00001000,
      S_SCROLL_TAIL = 8'b00010000,
      S_PUTC        = 8'b00100000,
      S_READ        = 8'b01000000,
      S_DONE        = 8'b10000000
   } state_type;

   state_type state_ff, state_in;

   logic [CHAR_W-1:0] colour_ff, colour_in;
   logic [COL_W-1:0]  scr_cols_ff, scr_cols_in;
   logic [ROW_W-1:0]  scr_rows_ff, scr_rows_in;

   logic [COL_W-1:0]  cur_col_ff, cur_col_in;
   logic [ROW_W-1:0]  cur_row_ff, cur_row_in;
   logic [COL_W-1:0]  cols_ff, cols_in;
   logic [ROW_W-1:0]  rows_ff, rows_in;
   logic [CHAR_W-1:0] char_ff, char_in;
   logic              put_ff, put_in;
   logic [COL_W-1:0]  wcol_ff, wcol_in;
   logic [ROW_W-1:0]  wrow_ff, wrow_in;
   logic [ROW_W-1:0]  wend_ff, wend_in;
   logic [COL_W-1:0]  scol_ff, scol_in;
   logic [ROW_W-1:0]  srow_ff, srow_in;
   logic              pend_ff, pend_in;
   logic [ADDR_W-1:0] pend_addr_ff, pend_addr_in;
   logic [ADDR_W-1:0] clr_addr_ff, clr_addr_in;
   logic [CHAR_W-1:0] rd_char_ff, rd_char_in;
   logic [CHAR_W-1:0] rd_colour_ff, rd_colour_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]  rsp_data_ff, rsp_data_in;

   logic              ram_we;
   logic [ADDR_W-1:0] ram_waddr;
   logic [CELL_W-1:0] ram_wdata;
   logic [ADDR_W-1:0] ram_raddr;
   logic [CELL_W-1:0] ram_rdata;

   // clamped view of sizes, cursor and request coordinates
   logic [COL_W-1:0]  eff_cols;
   logic [ROW_W-1:0]  eff_rows;
   logic [COL_W-1:0]  c_col;
   logic [ROW_W-1:0]  c_row;
   logic [COL_W-1:0]  p_col;
   logic [ROW_W-1:0]  p_row;
   logic [CMD_W-1:0]  req_cmd;
   logic [CHAR_W-1:0] req_char;
   logic [COL_W-1:0]  req_col;
   logic [ROW_W-1:0]  req_row;
   logic              csr_wr;
   logic [POS_W-1:0]  cur_pos;

   assign req_cmd  = req_tuser;
   assign req_char = req_tdata[CHAR_W-1:0];
   assign req_col  = req_tdata[CHAR_W +: COL_W];
   assign req_row  = req_tdata[CHAR_W+COL_W +: ROW_W];

   tcw_ram #(
      .WIDTH (CELL_W),
      .DEPTH (CELL_COUNT)
   ) u_cell_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   always_comb begin
      eff_cols = scr_cols_ff;
      if (scr_cols_ff == '0) begin
         eff_cols = COL_W'(1);
      end else if (32'(scr_cols_ff) > MAX_COLUMNS) begin
         eff_cols = COL_W'(MAX_COLUMNS);
      end
      eff_rows = scr_rows_ff;
      if (scr_rows_ff == '0) begin
         eff_rows = ROW_W'(1);
      end else if (32'(scr_rows_ff) > ROW_LIMIT) begin
         eff_rows = ROW_W'(ROW_LIMIT);
      end
      c_row = (cur_row_ff > eff_rows - ROW_W'(1)) ? eff_rows - ROW_W'(1) : cur_row_ff;
      c_col = (cur_col_ff > eff_cols) ? eff_cols : cur_col_ff;
      p_col = (req_col > eff_cols - COL_W'(1)) ? eff_cols - COL_W'(1) : req_col;
      p_row = (req_row > eff_rows - ROW_W'(1)) ? eff_rows - ROW_W'(1) : req_row;
   end

   assign cur_pos = POS_W'(cur_col_ff) + POS_W'(cols_ff) * POS_W'(cur_row_ff);

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      colour_in   = colour_ff;
      scr_cols_in = scr_cols_ff;
      scr_rows_in = scr_rows_ff;
      if (csr_wr) begin
         case (csr_paddr[3:2])
            REG_COLOUR:  colour_in   = csr_pwdata[CHAR_W-1:0];
            REG_COLUMNS: scr_cols_in = csr_pwdata[COL_W-1:0];
            REG_ROWS:    scr_rows_in = csr_pwdata[ROW_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         REG_COLOUR:  csr_prdata = CSR_DW'(colour_ff);
         REG_COLUMNS: csr_prdata = CSR_DW'(scr_cols_ff);
         REG_ROWS:    csr_prdata = CSR_DW'(scr_rows_ff);
         default:     csr_prdata = '0;
      endcase
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // command sequencer
   always_comb begin
      state_in     = state_ff;
      cur_col_in   = cur_col_ff;
      cur_row_in   = cur_row_ff;
      cols_in      = cols_ff;
      rows_in      = rows_ff;
      char_in      = char_ff;
      put_in       = put_ff;
      wcol_in      = wcol_ff;
      wrow_in      = wrow_ff;
      wend_in      = wend_ff;
      scol_in      = scol_ff;
      srow_in      = srow_ff;
      pend_in      = pend_ff;
      pend_addr_in = pend_addr_ff;
      clr_addr_in  = clr_addr_ff;
      rd_char_in   = rd_char_ff;
      rd_colour_in = rd_colour_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in  = rsp_data_ff;
      ram_we       = 1'b0;
      ram_waddr    = cell_addr(wcol_ff, wrow_ff);
      ram_wdata    = {colour_ff, BLANK_CHAR};
      ram_raddr    = cell_addr(p_col, p_row);

      case (state_ff)
         S_CLEAR: begin
            ram_we      = 1'b1;
            ram_waddr   = clr_addr_ff;
            ram_wdata   = {RESET_COLOUR, BLANK_CHAR};
            clr_addr_in = clr_addr_ff + ADDR_W'(1);
            if (32'(clr_addr_ff) == CELL_COUNT - 1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_tvalid) begin
               cols_in      = eff_cols;
               rows_in      = eff_rows;
               char_in      = req_char;
               put_in       = 1'b0;
               pend_in      = 1'b0;
               rd_char_in   = '0;
               rd_colour_in = '0;
               cur_col_in   = c_col;
               cur_row_in   = c_row;
               case (req_cmd)
                  CMD_PRINT: begin
                     if (req_char == NEWLINE_CHAR || c_col >= eff_cols) begin
                        put_in     = (req_char != NEWLINE_CHAR);
                        cur_col_in = '0;
                        wcol_in    = '0;
                        if (c_row + ROW_W'(1) < eff_rows) begin
                           cur_row_in = c_row + ROW_W'(1);
                           wrow_in    = c_row + ROW_W'(1);
                           wend_in    = c_row + ROW_W'(1);
                           state_in   = S_WIPE;
                        end else if (eff_rows == ROW_W'(1)) begin
                           wrow_in  = '0;
                           wend_in  = '0;
                           state_in = S_WIPE;
                        end else begin
                           scol_in  = '0;
                           srow_in  = ROW_W'(1);
                           state_in = S_SCROLL;
                        end
                     end else begin
                        state_in = S_PUTC;
                     end
                  end
                  CMD_SET_CUR: begin
                     cur_col_in = p_col;
                     cur_row_in = p_row;
                     state_in   = S_DONE;
                  end
                  CMD_CLR_ROW: begin
                     cur_col_in = '0;
                     cur_row_in = p_row;
                     wcol_in    = '0;
                     wrow_in    = p_row;
                     wend_in    = p_row;
                     state_in   = S_WIPE;
                  end
                  CMD_CLR_SCR: begin
                     cur_col_in = '0;
                     cur_row_in = '0;
                     wcol_in    = '0;
                     wrow_in    = '0;
                     wend_in    = eff_rows - ROW_W'(1);
                     state_in   = S_WIPE;
                  end
                  CMD_READ_CELL: begin
                     state_in = S_READ;
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_WIPE: begin
            ram_we = 1'b1;
            if (wcol_ff == cols_ff - COL_W'(1)) begin
               wcol_in = '0;
               if (wrow_ff == wend_ff) begin
                  state_in = put_ff ? S_PUTC : S_DONE;
               end else begin
                  wrow_in = wrow_ff + ROW_W'(1);
               end
            end else begin
               wcol_in = wcol_ff + COL_W'(1);
            end
         end
         S_SCROLL: begin
            // read one cell per cycle, write the previous one a row higher
            ram_raddr    = cell_addr(scol_ff, srow_ff);
            pend_in      = 1'b1;
            pend_addr_in = cell_addr(scol_ff, srow_ff) - ADDR_W'(MAX_COLUMNS);
            ram_we       = pend_ff;
            ram_waddr    = pend_addr_ff;
            ram_wdata    = ram_rdata;
            if (scol_ff == cols_ff - COL_W'(1)) begin
               scol_in = '0;
               if (srow_ff == rows_ff - ROW_W'(1)) begin
                  state_in = S_SCROLL_TAIL;
               end else begin
                  srow_in = srow_ff + ROW_W'(1);
               end
            end else begin
               scol_in = scol_ff + COL_W'(1);
            end
         end
         S_SCROLL_TAIL: begin
            ram_we    = 1'b1;
            ram_waddr = pend_addr_ff;
            ram_wdata = ram_rdata;
            pend_in   = 1'b0;
            wcol_in   = '0;
            wrow_in   = rows_ff - ROW_W'(1);
            wend_in   = rows_ff - ROW_W'(1);
            state_in  = S_WIPE;
         end
         S_PUTC: begin
            ram_we     = 1'b1;
            ram_waddr  = cell_addr(cur_col_ff, cur_row_ff);
            ram_wdata  = {colour_ff, char_ff};
            cur_col_in = cur_col_ff + COL_W'(1);
            state_in   = S_DONE;
         end
         S_READ: begin
            rd_char_in   = ram_rdata[CHAR_W-1:0];
            rd_colour_in = ram_rdata[CELL_W-1:CHAR_W];
            state_in     = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = RSP_W'({rd_colour_ff, rd_char_ff, cur_pos});
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         colour_ff    <= RESET_COLOUR;
         scr_cols_ff  <= RESET_COLS;
         scr_rows_ff  <= RESET_ROWS;
         cur_col_ff   <= '0;
         cur_row_ff   <= '0;
         clr_addr_ff  <= '0;
         pend_ff      <= 1'b0;
         put_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         colour_ff    <= colour_in;
         scr_cols_ff  <= scr_cols_in;
         scr_rows_ff  <= scr_rows_in;
         cur_col_ff   <= cur_col_in;
         cur_row_ff   <= cur_row_in;
         clr_addr_ff  <= clr_addr_in;
         pend_ff      <= pend_in;
         put_ff       <= put_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cols_ff      <= cols_in;
      rows_ff      <= rows_in;
      char_ff      <= char_in;
      wcol_ff      <= wcol_in;
      wrow_ff      <= wrow_in;
      wend_ff      <= wend_in;
      scol_ff      <= scol_in;
      srow_ff      <= srow_in;
      pend_addr_ff <= pend_addr_in;
      rd_char_ff   <= rd_char_in;
      rd_colour_ff <= rd_colour_in;
      rsp_data_ff  <= rsp_data_in;
   end

endmodule
